// ===== hdl/lob_pkg.sv =====
package lob_pkg;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CANCEL  = 3'd1;
  localparam logic [2:0] OP_POP_BID = 3'd2;
  localparam logic [2:0] OP_POP_ASK = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_CANCEL,
    CMD_POP_BID,
    CMD_POP_ASK,
    CMD_QUERY
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_QTY    = 3'd1,
    ST_UNKNOWN_ID = 3'd2,
    ST_FULL       = 3'd3,
    ST_DUP_ID     = 3'd4,
    ST_SIDE_EMPTY = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e               op;
    logic [31:0]        order_ref;
    logic               side;
    logic [31:0]        price;
    logic signed [31:0] open_qty;
    logic               bad_qty;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [31:0]        price;
    logic signed [31:0] open_qty;
  } sdat_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        price;
    logic [31:0]        id;
    logic signed [31:0] open_qty;
  } top_t;

  typedef struct packed {
    logic        accepted;
    status_e     status;
    top_t        bid;
    top_t        ask;
    logic [10:0] live_count;
  } res_t;

  // price a ranks ahead of price b on side sd (1 = sell)
  function automatic logic ahead(input logic sd, input logic [31:0] a, input logic [31:0] b);
    ahead = sd ? (a < b) : (a > b);
  endfunction

endpackage

// ===== hdl/lob_if.sv =====
interface lob_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [31:0]        order_ref;
  logic               side;
  logic [31:0]        limit_price;
  logic signed [31:0] quantity;
  logic signed [31:0] open_quantity;

  modport source (output valid, opcode, order_ref, side, limit_price, quantity, open_quantity,
                  input ready);
  modport sink (input valid, opcode, order_ref, side, limit_price, quantity, open_quantity,
                output ready);
endinterface

interface lob_res_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [2:0]         status;
  logic               bid_valid;
  logic [31:0]        bid_price;
  logic [31:0]        bid_id;
  logic signed [31:0] bid_open;
  logic               ask_valid;
  logic [31:0]        ask_price;
  logic [31:0]        ask_id;
  logic signed [31:0] ask_open;
  logic [10:0]        live_count;

  modport source (output valid, accepted, status, bid_valid, bid_price, bid_id, bid_open,
                  ask_valid, ask_price, ask_id, ask_open, live_count, input ready);
  modport sink (input valid, accepted, status, bid_valid, bid_price, bid_id, bid_open,
                ask_valid, ask_price, ask_id, ask_open, live_count, output ready);
endinterface

// ===== hdl/lob_ram.sv =====
module lob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lob_front.sv =====
module lob_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  lob_cmd_if.sink        cmd_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output lob_pkg::cmd_t  q_cmd_o
);

  lob_pkg::cmd_t ent_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  lob_pkg::cmd_t cls;
  logic          push, pop;

  always_comb begin
    cls.order_ref = cmd_i.order_ref;
    cls.side      = cmd_i.side;
    cls.price     = cmd_i.limit_price;
    cls.open_qty  = cmd_i.open_quantity;
    cls.bad_qty   = (cmd_i.quantity <= 0) || (cmd_i.open_quantity <= 0);
    case (cmd_i.opcode)
      lob_pkg::OP_ADD:     cls.op = lob_pkg::CMD_ADD;
      lob_pkg::OP_CANCEL:  cls.op = lob_pkg::CMD_CANCEL;
      lob_pkg::OP_POP_BID: cls.op = lob_pkg::CMD_POP_BID;
      lob_pkg::OP_POP_ASK: cls.op = lob_pkg::CMD_POP_ASK;
      default:             cls.op = lob_pkg::CMD_QUERY;
    endcase
  end

  assign cmd_i.ready = (cnt_q != 2'd2);
  assign push        = cmd_i.valid && cmd_i.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign pop         = q_valid_o && q_ready_i;
  assign q_cmd_o     = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/lob_back.sv =====
module lob_back #(
  parameter int ORDER_SLOTS  = 1024,
  parameter int PRICE_LEVELS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  lob_pkg::cmd_t q_cmd_i,
  lob_res_if.source     res_o
);

  localparam int AW  = $clog2(ORDER_SLOTS);
  localparam int CW  = $clog2(ORDER_SLOTS + 1);
  localparam int LW  = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam int NW  = $clog2(PRICE_LEVELS + 1);
  localparam int LAW = LW + 1;

  typedef struct packed {
    logic [31:0]   price;
    logic [AW-1:0] first;
    logic [AW-1:0] last;
  } lvl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_F_LV, S_F_LW, S_F_ND, S_F_MISS,
    S_A_LV, S_A_LW, S_A_NEW, S_A_ALLOC, S_A_POP, S_A_WR,
    S_SH_UP, S_SH_UW, S_SH_DN, S_SH_DW,
    S_P_LV, S_P_LW, S_P_ND, S_RM,
    S_TOP, S_T_LV, S_T_LW, S_T_SD, S_OUT
  } state_e;

  state_e           state_q;
  lob_pkg::cmd_t    cmd_q;
  lob_pkg::status_e status_q;
  logic [NW-1:0]    used_q [2];
  logic [CW-1:0]    live_q, fresh_q, fcnt_q;
  logic             sd_q, isfirst_q, app_q;
  logic [NW-1:0]    lev_q, shi_q;
  logic [AW-1:0]    p_q, prev_q, nxt_q, slot_q;
  lvl_t             lvl_q;
  lob_pkg::top_t    top_q [2];
  lob_pkg::res_t    res_q;
  logic             res_valid_q;

  logic                  lvl_we;
  logic [LAW-1:0]        lvl_waddr, lvl_raddr;
  lvl_t                  lvl_wdata, lvl_rd;
  logic [AW-1:0]         slot_raddr;
  logic                  sdat_we;
  lob_pkg::sdat_t        sdat_wdata, sdat_rd;
  logic                  nxt_we;
  logic [AW-1:0]         nxt_waddr, nxt_wdata, nxt_rd;
  logic                  free_we;
  logic [AW-1:0]         free_raddr, free_waddr, free_rd;
  logic [NW-1:0]         shm1, shp1;
  logic [CW-1:0]         fcnt_m1;

  assign shm1    = shi_q - NW'(1);
  assign shp1    = shi_q + NW'(1);
  assign fcnt_m1 = fcnt_q - CW'(1);

  lob_ram #(.WIDTH($bits(lvl_t)), .DEPTH(2 ** LAW)) u_lvl_ram (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .raddr_i(lvl_raddr), .rdata_o(lvl_rd)
  );

  lob_ram #(.WIDTH($bits(lob_pkg::sdat_t)), .DEPTH(ORDER_SLOTS)) u_sdat_ram (
    .clk_i, .we_i(sdat_we), .waddr_i(slot_q), .wdata_i(sdat_wdata),
    .raddr_i(slot_raddr), .rdata_o(sdat_rd)
  );

  lob_ram #(.WIDTH(AW), .DEPTH(ORDER_SLOTS)) u_next_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(slot_raddr), .rdata_o(nxt_rd)
  );

  lob_ram #(.WIDTH(AW), .DEPTH(ORDER_SLOTS)) u_free_ram (
    .clk_i, .we_i(free_we), .waddr_i(free_waddr), .wdata_i(p_q),
    .raddr_i(free_raddr), .rdata_o(free_rd)
  );

  assign q_ready_o  = (state_q == S_IDLE);
  assign sdat_wdata = '{id: cmd_q.order_ref, price: cmd_q.price, open_qty: cmd_q.open_qty};
  assign free_raddr = fcnt_m1[AW-1:0];
  assign free_waddr = fcnt_q[AW-1:0];

  always_comb begin
    lvl_raddr  = {sd_q, lev_q[LW-1:0]};
    lvl_we     = 1'b0;
    lvl_waddr  = {sd_q, lev_q[LW-1:0]};
    lvl_wdata  = lvl_q;
    slot_raddr = p_q;
    sdat_we    = 1'b0;
    nxt_we     = 1'b0;
    nxt_waddr  = prev_q;
    nxt_wdata  = nxt_q;
    free_we    = 1'b0;
    case (state_q)
      S_F_LW, S_P_LW, S_T_LW: slot_raddr = lvl_rd.first;
      S_F_ND: slot_raddr = nxt_rd;
      S_A_WR: begin
        sdat_we = 1'b1;
        if (app_q) begin
          nxt_we    = 1'b1;
          nxt_waddr = lvl_q.last;
          nxt_wdata = slot_q;
          lvl_we    = 1'b1;
          lvl_wdata = '{price: lvl_q.price, first: lvl_q.first, last: slot_q};
        end
      end
      S_SH_UP: begin
        if (shi_q == lev_q) begin
          lvl_we    = 1'b1;
          lvl_wdata = '{price: cmd_q.price, first: slot_q, last: slot_q};
        end else begin
          lvl_raddr = {sd_q, shm1[LW-1:0]};
        end
      end
      S_SH_UW, S_SH_DW: begin
        lvl_we    = 1'b1;
        lvl_waddr = {sd_q, shi_q[LW-1:0]};
        lvl_wdata = lvl_rd;
      end
      S_SH_DN: lvl_raddr = {sd_q, shp1[LW-1:0]};
      S_RM: begin
        free_we = 1'b1;
        if (isfirst_q) begin
          if (p_q != lvl_q.last) begin
            lvl_we    = 1'b1;
            lvl_wdata = '{price: lvl_q.price, first: nxt_q, last: lvl_q.last};
          end
        end else if (p_q == lvl_q.last) begin
          lvl_we    = 1'b1;
          lvl_wdata = '{price: lvl_q.price, first: lvl_q.first, last: prev_q};
        end else begin
          nxt_we = 1'b1;
        end
      end
      S_P_LV, S_T_LV: lvl_raddr = {sd_q, {LW{1'b0}}};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= q_cmd_i;
        lev_q <= '0;
        sd_q  <= (q_cmd_i.op == lob_pkg::CMD_POP_ASK);
        if (q_cmd_i.op == lob_pkg::CMD_ADD && q_cmd_i.bad_qty) begin
          status_q <= lob_pkg::ST_BAD_QTY;
        end else if ((q_cmd_i.op == lob_pkg::CMD_POP_BID && used_q[0] == '0) ||
                     (q_cmd_i.op == lob_pkg::CMD_POP_ASK && used_q[1] == '0)) begin
          status_q <= lob_pkg::ST_SIDE_EMPTY;
        end else begin
          status_q <= lob_pkg::ST_OK;
        end
      end
      S_F_LV: begin
        if (lev_q == used_q[sd_q] && !sd_q) begin
          sd_q  <= 1'b1;
          lev_q <= '0;
        end
      end
      S_F_LW, S_P_LW: begin
        lvl_q     <= lvl_rd;
        p_q       <= lvl_rd.first;
        isfirst_q <= 1'b1;
      end
      S_F_ND: begin
        nxt_q <= nxt_rd;
        if (sdat_rd.id == cmd_q.order_ref) begin
          if (cmd_q.op == lob_pkg::CMD_ADD) status_q <= lob_pkg::ST_DUP_ID;
        end else if (p_q == lvl_q.last) begin
          lev_q <= lev_q + NW'(1);
        end else begin
          prev_q    <= p_q;
          p_q       <= nxt_rd;
          isfirst_q <= 1'b0;
        end
      end
      S_F_MISS: begin
        if (cmd_q.op == lob_pkg::CMD_CANCEL) begin
          status_q <= lob_pkg::ST_UNKNOWN_ID;
        end else if (live_q == CW'(ORDER_SLOTS)) begin
          status_q <= lob_pkg::ST_FULL;
        end
        sd_q  <= cmd_q.side;
        lev_q <= '0;
      end
      S_A_LW: begin
        lvl_q <= lvl_rd;
        app_q <= (lvl_rd.price == cmd_q.price);
        if (lob_pkg::ahead(sd_q, lvl_rd.price, cmd_q.price)) lev_q <= lev_q + NW'(1);
      end
      S_A_NEW: begin
        app_q <= 1'b0;
        if (used_q[sd_q] == NW'(PRICE_LEVELS)) status_q <= lob_pkg::ST_FULL;
      end
      S_A_ALLOC: begin
        if (fcnt_q == '0) slot_q <= fresh_q[AW-1:0];
      end
      S_A_POP: slot_q <= free_rd;
      S_A_WR: shi_q <= used_q[sd_q];
      S_SH_UW: shi_q <= shm1;
      S_SH_DW: shi_q <= shp1;
      S_P_ND: nxt_q <= nxt_rd;
      S_RM: shi_q <= lev_q;
      S_TOP: sd_q <= 1'b0;
      S_T_LV: begin
        if (used_q[sd_q] == '0) begin
          top_q[sd_q] <= '0;
          sd_q        <= 1'b1;
        end
      end
      S_T_LW: begin
        top_q[sd_q].valid <= 1'b1;
        top_q[sd_q].price <= lvl_rd.price;
      end
      S_T_SD: begin
        top_q[sd_q].id       <= sdat_rd.id;
        top_q[sd_q].open_qty <= sdat_rd.open_qty;
        sd_q                 <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q[0]   <= '0;
      used_q[1]   <= '0;
      live_q      <= '0;
      fresh_q     <= '0;
      fcnt_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (state_q == S_OUT && (!res_valid_q || res_o.ready)) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            case (q_cmd_i.op)
              lob_pkg::CMD_ADD:     state_q <= q_cmd_i.bad_qty ? S_TOP : S_F_LV;
              lob_pkg::CMD_CANCEL:  state_q <= S_F_LV;
              lob_pkg::CMD_POP_BID: state_q <= (used_q[0] == '0) ? S_TOP : S_P_LV;
              lob_pkg::CMD_POP_ASK: state_q <= (used_q[1] == '0) ? S_TOP : S_P_LV;
              default:              state_q <= S_TOP;
            endcase
          end
        end
        S_F_LV: begin
          if (lev_q == used_q[sd_q]) begin
            if (sd_q) state_q <= S_F_MISS;
          end else begin
            state_q <= S_F_LW;
          end
        end
        S_F_LW: state_q <= S_F_ND;
        S_F_ND: begin
          if (sdat_rd.id == cmd_q.order_ref) begin
            state_q <= (cmd_q.op == lob_pkg::CMD_ADD) ? S_TOP : S_RM;
          end else if (p_q == lvl_q.last) begin
            state_q <= S_F_LV;
          end
        end
        S_F_MISS: begin
          if (cmd_q.op == lob_pkg::CMD_CANCEL || live_q == CW'(ORDER_SLOTS)) begin
            state_q <= S_TOP;
          end else begin
            state_q <= S_A_LV;
          end
        end
        S_A_LV: state_q <= (lev_q == used_q[sd_q]) ? S_A_NEW : S_A_LW;
        S_A_LW: begin
          if (lob_pkg::ahead(sd_q, lvl_rd.price, cmd_q.price)) begin
            state_q <= S_A_LV;
          end else if (lvl_rd.price == cmd_q.price) begin
            state_q <= S_A_ALLOC;
          end else begin
            state_q <= S_A_NEW;
          end
        end
        S_A_NEW: state_q <= (used_q[sd_q] == NW'(PRICE_LEVELS)) ? S_TOP : S_A_ALLOC;
        S_A_ALLOC: begin
          if (fcnt_q != '0) begin
            fcnt_q  <= fcnt_m1;
            state_q <= S_A_POP;
          end else begin
            fresh_q <= fresh_q + CW'(1);
            state_q <= S_A_WR;
          end
        end
        S_A_POP: state_q <= S_A_WR;
        S_A_WR: begin
          live_q  <= live_q + CW'(1);
          state_q <= app_q ? S_TOP : S_SH_UP;
        end
        S_SH_UP: begin
          if (shi_q == lev_q) begin
            used_q[sd_q] <= used_q[sd_q] + NW'(1);
            state_q      <= S_TOP;
          end else begin
            state_q <= S_SH_UW;
          end
        end
        S_SH_UW: state_q <= S_SH_UP;
        S_SH_DN: begin
          if (shp1 == used_q[sd_q]) begin
            used_q[sd_q] <= used_q[sd_q] - NW'(1);
            state_q      <= S_TOP;
          end else begin
            state_q <= S_SH_DW;
          end
        end
        S_SH_DW: state_q <= S_SH_DN;
        S_P_LV: state_q <= S_P_LW;
        S_P_LW: state_q <= S_P_ND;
        S_P_ND: state_q <= S_RM;
        S_RM: begin
          fcnt_q  <= fcnt_q + CW'(1);
          live_q  <= live_q - CW'(1);
          state_q <= (isfirst_q && p_q == lvl_q.last) ? S_SH_DN : S_TOP;
        end
        S_TOP: state_q <= S_T_LV;
        S_T_LV: begin
          if (used_q[sd_q] != '0) begin
            state_q <= S_T_LW;
          end else if (sd_q) begin
            state_q <= S_OUT;
          end
        end
        S_T_LW: state_q <= S_T_SD;
        S_T_SD: state_q <= sd_q ? S_OUT : S_T_LV;
        S_OUT: begin
          if (!res_valid_q || res_o.ready) begin
            res_q.accepted   <= (status_q == lob_pkg::ST_OK);
            res_q.status     <= status_q;
            res_q.bid        <= top_q[0];
            res_q.ask        <= top_q[1];
            res_q.live_count <= 11'(live_q);
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.accepted   = res_q.accepted;
  assign res_o.status     = res_q.status;
  assign res_o.bid_valid  = res_q.bid.valid;
  assign res_o.bid_price  = res_q.bid.price;
  assign res_o.bid_id     = res_q.bid.id;
  assign res_o.bid_open   = res_q.bid.open_qty;
  assign res_o.ask_valid  = res_q.ask.valid;
  assign res_o.ask_price  = res_q.ask.price;
  assign res_o.ask_id     = res_q.ask.id;
  assign res_o.ask_open   = res_q.ask.open_qty;
  assign res_o.live_count = res_q.live_count;

  // slot accounting: every slot handed out is live or back on the free stack
  a_slot_books: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> (32'(live_q) + 32'(fcnt_q) == 32'(fresh_q)))
    else $error("slot accounting mismatch");

  a_live_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_q) <= ORDER_SLOTS)
    else $error("live count above capacity");

  a_levels_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q[0]) <= PRICE_LEVELS && 32'(used_q[1]) <= PRICE_LEVELS)
    else $error("level count above capacity");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i && q_ready_o |=> !(res_valid_q && $rose(res_valid_q)))
    else $error("result issued without executing command");

endmodule

// ===== hdl/limit_order_book.sv =====
// Price-time priority limit order book. Commands (add, cancel by id, remove best bid, remove
// best ask, query) enter through a two-entry registered queue and execute one at a time in a
// sequencer over RAMs with registered reads: order slots, slot links, a free-slot stack and
// the sorted price levels of both sides. Every command returns one result with status, top
// of both sides and the live count. In the sequencer a command is taken, does its own work,
// then reads the top of book of each side, and finally loads the result. Add and cancel
// first search for the id level by level, scanning the orders of each level, bid side then
// ask side; add then passes levels while locating the price and places the order. Inserting
// or dropping a level moves the levels behind it. A result that is not taken holds the
// sequencer.
// No initialization pass follows reset.
module limit_order_book #(
  parameter int ORDER_SLOTS  = 1024,
  parameter int PRICE_LEVELS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lob_cmd_if.sink   cmd_i,
  lob_res_if.source res_o
);

  logic          q_valid, q_ready;
  lob_pkg::cmd_t q_cmd;

  lob_front u_front (
    .clk_i, .rst_ni, .cmd_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  lob_back #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd), .res_o
  );

endmodule

// ===== verif/tb_limit_order_book.sv =====
module tb_limit_order_book;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int         LEVEL_CAP       = 64;
  localparam int         SLOT_CAP        = 1024;
  localparam int         IDLE_LIMIT      = 20000;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        id;
    logic               side;
    logic [31:0]        px;
    logic signed [31:0] qty;
    logic signed [31:0] oqty;
  } order_cmd_t;

  typedef struct {
    logic [31:0]        id;
    logic               side;
    logic [31:0]        px;
    logic signed [31:0] oqty;
    int unsigned        seq;
  } resting_t;

  typedef struct {
    order_cmd_t       c;
    bit               typed;
    lob_pkg::status_e st;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  lob_cmd_if cmd_if ();
  lob_res_if res_if ();

  limit_order_book u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  resting_t      book[$];
  int unsigned   seq_ctr;
  lob_pkg::res_t tob_q[$];
  int            errors;
  int            results_seen;
  int            idle_cycles;
  bit            busy_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // best resting order on a side: best price, then oldest
  function automatic int best_of(logic sd);
    int b;
    b = -1;
    foreach (book[i]) begin
      if (book[i].side == sd) begin
        if (b < 0) b = i;
        else if (book[i].px == book[b].px) begin
          if (book[i].seq < book[b].seq) b = i;
        end else if (lob_pkg::ahead(sd, book[i].px, book[b].px)) b = i;
      end
    end
    return b;
  endfunction

  function automatic int level_count(logic sd);
    bit seen[logic [31:0]];
    foreach (book[i]) if (book[i].side == sd) seen[book[i].px] = 1'b1;
    return seen.num();
  endfunction

  function automatic bit level_exists(logic sd, logic [31:0] px);
    foreach (book[i]) if (book[i].side == sd && book[i].px == px) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int find_id(logic [31:0] id);
    foreach (book[i]) if (book[i].id == id) return i;
    return -1;
  endfunction

  function automatic lob_pkg::top_t top_of(logic sd);
    lob_pkg::top_t t;
    int            b;
    t = '0;
    b = best_of(sd);
    if (b >= 0) begin
      t.valid    = 1'b1;
      t.price    = book[b].px;
      t.id       = book[b].id;
      t.open_qty = book[b].oqty;
    end
    return t;
  endfunction

  function automatic lob_pkg::res_t apply_cmd(order_cmd_t c);
    lob_pkg::res_t    r;
    lob_pkg::status_e st;
    resting_t         o;
    int               f;
    st = lob_pkg::ST_OK;
    case (c.op)
      lob_pkg::OP_ADD: begin
        if (c.qty <= 0 || c.oqty <= 0) st = lob_pkg::ST_BAD_QTY;
        else if (find_id(c.id) >= 0) st = lob_pkg::ST_DUP_ID;
        else if (book.size() >= SLOT_CAP) st = lob_pkg::ST_FULL;
        else if (!level_exists(c.side, c.px) && level_count(c.side) >= LEVEL_CAP)
          st = lob_pkg::ST_FULL;
        else begin
          o.id = c.id; o.side = c.side; o.px = c.px; o.oqty = c.oqty; o.seq = seq_ctr++;
          book = {book, o};
        end
      end
      lob_pkg::OP_CANCEL: begin
        f = find_id(c.id);
        if (f < 0) st = lob_pkg::ST_UNKNOWN_ID;
        else book.delete(f);
      end
      lob_pkg::OP_POP_BID, lob_pkg::OP_POP_ASK: begin
        f = best_of(c.op == lob_pkg::OP_POP_ASK);
        if (f < 0) st = lob_pkg::ST_SIDE_EMPTY;
        else book.delete(f);
      end
      default: ;
    endcase
    r.accepted   = (st == lob_pkg::ST_OK);
    r.status     = st;
    r.bid        = top_of(1'b0);
    r.ask        = top_of(1'b1);
    r.live_count = 11'(book.size());
    return r;
  endfunction

  task automatic send_cmd(order_cmd_t c, bit typed = 1'b0,
                          lob_pkg::status_e st = lob_pkg::ST_OK);
    lob_pkg::res_t e;
    int            gap;
    gap = busy_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= c.op;
    cmd_if.order_ref     <= c.id;
    cmd_if.side          <= c.side;
    cmd_if.limit_price   <= c.px;
    cmd_if.quantity      <= c.qty;
    cmd_if.open_quantity <= c.oqty;
    do @(posedge clk_i); while (!cmd_if.ready);
    e = apply_cmd(c);
    if (typed) begin
      e.status   = st;
      e.accepted = (st == lob_pkg::ST_OK);
    end
    tob_q = {tob_q, e};
  endtask

  function automatic order_cmd_t mk(logic [2:0] op, logic [31:0] id, int sd,
                                    logic [31:0] px, logic signed [31:0] q,
                                    logic signed [31:0] oq);
    order_cmd_t c;
    c.op = op; c.id = id; c.side = sd[0]; c.px = px; c.qty = q; c.oqty = oq;
    return c;
  endfunction

  function automatic order_cmd_t rand_cmd();
    order_cmd_t  c;
    int unsigned pick;
    c = mk(lob_pkg::OP_QUERY, $urandom, $urandom_range(0, 1), $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (book.size() > 150 && pick < 50) pick = pick + 50;
    if (pick < 50) begin
      c.op = lob_pkg::OP_ADD;
      if ($urandom_range(0, 9) != 0) c.id = $urandom_range(0, 255);
      if ($urandom_range(0, 9) != 0) c.px = 32'd1000 + $urandom_range(0, 90);
      if ($urandom_range(0, 9) != 0) c.qty = $urandom_range(1, 1000);
      if ($urandom_range(0, 9) != 0) c.oqty = $urandom_range(1, 1000);
    end else if (pick < 75) begin
      c.op = lob_pkg::OP_CANCEL;
      if (book.size() > 0 && $urandom_range(0, 9) < 7)
        c.id = book[$urandom_range(0, book.size() - 1)].id;
      else if ($urandom_range(0, 1)) c.id = $urandom_range(0, 255);
    end else if (pick < 85) c.op = lob_pkg::OP_POP_BID;
    else if (pick < 95) c.op = lob_pkg::OP_POP_ASK;
    else if (pick < 98) c.op = lob_pkg::OP_QUERY;
    else c.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result sink
  initial begin
    lob_pkg::res_t e;
    int            stall;
    bit            held;
    held = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = busy_burst ? 0 : $urandom_range(0, 11);
      if (!held && results_seen >= 300) begin
        stall = 400;
        held  = 1'b1;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      results_seen++;
      if (tob_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = tob_q.pop_front();
        check_field("accepted", 32'(e.accepted), 32'(res_if.accepted));
        check_field("status", 32'(e.status), 32'(res_if.status));
        check_field("bid_valid", 32'(e.bid.valid), 32'(res_if.bid_valid));
        check_field("bid_price", e.bid.price, res_if.bid_price);
        check_field("bid_id", e.bid.id, res_if.bid_id);
        check_field("bid_open", e.bid.open_qty, res_if.bid_open);
        check_field("ask_valid", 32'(e.ask.valid), 32'(res_if.ask_valid));
        check_field("ask_price", e.ask.price, res_if.ask_price);
        check_field("ask_id", e.ask.id, res_if.ask_id);
        check_field("ask_open", e.ask.open_qty, res_if.ask_open);
        check_field("live_count", 32'(e.live_count), 32'(res_if.live_count));
      end
    end
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_limit_order_book: FAIL");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int        n;
    errors       = 0;
    results_seen = 0;
    seq_ctr      = 0;
    busy_burst   = 1'b0;
    rst_ni       = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.opcode        = lob_pkg::OP_QUERY;
    cmd_if.order_ref     = '0;
    cmd_if.side          = 1'b0;
    cmd_if.limit_price   = '0;
    cmd_if.quantity      = '0;
    cmd_if.open_quantity = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{mk(lob_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1'b1, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_POP_BID, 0, 0, 0, 0, 0), 1'b1, lob_pkg::ST_SIDE_EMPTY},
      '{mk(lob_pkg::OP_POP_ASK, 0, 0, 0, 0, 0), 1'b1, lob_pkg::ST_SIDE_EMPTY},
      '{mk(lob_pkg::OP_CANCEL, 5, 0, 0, 0, 0), 1'b1, lob_pkg::ST_UNKNOWN_ID},
      '{mk(lob_pkg::OP_ADD, 7, 0, 10, 0, 5), 1'b1, lob_pkg::ST_BAD_QTY},
      '{mk(lob_pkg::OP_ADD, 7, 0, 10, -1, 5), 1'b1, lob_pkg::ST_BAD_QTY},
      '{mk(lob_pkg::OP_ADD, 7, 1, 10, 5, 32'sh8000_0000), 1'b1, lob_pkg::ST_BAD_QTY},
      '{mk(lob_pkg::OP_ADD, 1, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff), 1'b1, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_ADD, 32'hffff_ffff, 1, 32'hffff_ffff, 1, 1), 1'b1, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_ADD, 1, 1, 20, 3, 3), 1'b1, lob_pkg::ST_DUP_ID},
      '{mk(lob_pkg::OP_ADD, 2, 0, 0, 5, 9), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_ADD, 3, 0, 100, 1, 1), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_ADD, 4, 1, 50, 8, 2), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_ADD, 6, 1, 50, 4, 4), 1'b0, lob_pkg::ST_OK},
      '{mk(OP_UNUSED_FIRST, 0, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(OP_UNUSED_LAST, 0, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_CANCEL, 1, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_POP_BID, 0, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_CANCEL, 4, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_POP_ASK, 0, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_POP_ASK, 0, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_POP_BID, 0, 0, 0, 0, 0), 1'b0, lob_pkg::ST_OK},
      '{mk(lob_pkg::OP_POP_BID, 0, 0, 0, 0, 0), 1'b1, lob_pkg::ST_SIDE_EMPTY}
    };
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].st);

    // fill all price levels of each side, then two past the limit, then one more order at a known price
    for (int sd = 0; sd < 2; sd++) begin
      for (int i = 0; i < LEVEL_CAP + 2; i++)
        send_cmd(mk(lob_pkg::OP_ADD, 32'd10000 + 100 * sd + i, sd, 32'd5000 + i,
                    $urandom_range(1, 50), $urandom_range(1, 50)));
      send_cmd(mk(lob_pkg::OP_ADD, 32'd20000 + sd, sd, 32'd5000, 1, 1));
    end
    while (book.size() > 0)
      send_cmd(mk($urandom_range(0, 1) ? lob_pkg::OP_POP_BID : lob_pkg::OP_POP_ASK,
                  0, 0, 0, 0, 0));

    n = 0;
    while (n < 520) begin
      if (n % 100 == 0) busy_burst = ($urandom_range(0, 3) == 0);
      send_cmd(rand_cmd());
      n++;
    end
    busy_burst = 1'b0;
    cmd_if.valid <= 1'b0;
    while (tob_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("tb_limit_order_book: PASS");
    else $display("tb_limit_order_book: FAIL");
    $finish;
  end

endmodule
